@@ design/ptspkt_pkg.sv @@
// Package for the PES to transport stream packetizer.
// Holds shared sizes, stream byte codes, the controller state type and the command struct.
// No dependencies.
`default_nettype none

package ptspkt_pkg;

    // Packet geometry, all in bytes.
    localparam logic [7:0] PKT_LEN     = 8'd188;
    localparam logic [7:0] PKT_LAST    = 8'd187;
    localparam logic [7:0] BODY_LEN    = 8'd184;
    localparam logic [7:0] BODY_LAST   = 8'd183;
    localparam logic [7:0] PCR_BODY    = 8'd176;
    localparam logic [7:0] HDR_LEN     = 8'd14;
    localparam logic [7:0] SPLIT_TAKE  = 8'd182;
    localparam logic [7:0] AF_LEN_BASE = 8'd183;

    // Transport header codes.
    localparam logic [7:0] SYNC_BYTE      = 8'h47;
    localparam logic [3:0] AFC_PAYLOAD    = 4'h1;
    localparam logic [3:0] AFC_ADAPT_PAY  = 4'h3;
    localparam logic [7:0] AF_FLAGS_PCR   = 8'h10;
    localparam logic [7:0] AF_FLAGS_NONE  = 8'h00;
    localparam logic [7:0] STUFF_BYTE     = 8'hFF;
    localparam logic [6:0] PCR_EXT_MARK   = 7'h7E;
    localparam logic [7:0] PCR_EXT_LOW    = 8'h00;

    // PES header codes.
    localparam logic [7:0] PES_START_ZERO = 8'h00;
    localparam logic [7:0] PES_START_ONE  = 8'h01;
    localparam logic [7:0] PES_STREAM_ID  = 8'hE0;
    localparam logic [7:0] PES_FLAGS      = 8'h80;
    localparam logic [7:0] PES_HDR_DLEN   = 8'h05;
    localparam logic [3:0] PES_PTS_PREFIX = 4'h2;

    // Configuration reset value.
    localparam logic [12:0] PID_RESET = 13'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SPLIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       start;
        logic [7:0] off;
        logic [7:0] take;
        logic       pusi;
        logic       pcr;
        logic [3:0] cc;
        logic       unit_end;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic       latch_ts;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ design/ptspkt_ctrl.sv @@
// Controller for the PES to transport stream packetizer.
// Tracks unit, fill and continuity state and issues packet commands to the datapath.
// Depends on ptspkt_pkg.
`default_nettype none

module ptspkt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               byte_valid,
    input  wire logic               last_byte,
    input  wire logic               key_frame,
    input  wire logic               pkt_done,
    output logic                    in_stall,
    output ptspkt_pkg::dp_cmd_t     cmd
);

    ptspkt_pkg::ctrl_state_t state_reg;
    ptspkt_pkg::ctrl_state_t state_next;

    logic [7:0] fill_reg;
    logic [3:0] cc_reg;
    logic       first_reg;
    logic       pcr_reg;
    logic       open_reg;

    logic       accept;
    logic       opening;
    logic [7:0] fill0;
    logic [7:0] fill1;
    logic       pcr0;
    logic       first0;
    logic       full;
    logic       split;
    logic       close_pkt;
    logic       clear_unit;

    // Decode of the beat offered at the input.
    always_comb
    begin
        accept    = in_valid && (state_reg == ptspkt_pkg::ST_IDLE);
        opening   = !open_reg;
        fill0     = opening ? ptspkt_pkg::HDR_LEN : fill_reg;
        pcr0      = opening ? key_frame : pcr_reg;
        first0    = opening || first_reg;
        fill1     = fill0 + {7'd0, byte_valid};
        full      = pcr0 ? (fill1 >= ptspkt_pkg::PCR_BODY) : (fill1 >= ptspkt_pkg::BODY_LEN);
        split     = !full && last_byte && (fill1 == ptspkt_pkg::BODY_LAST);
        close_pkt = !full && last_byte && !split && (fill1 != 8'd0);
        clear_unit = full || last_byte;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptspkt_pkg::ST_IDLE:
            begin
                if (accept && split)
                    state_next = ptspkt_pkg::ST_SPLIT;
                else if (accept && (full || close_pkt))
                    state_next = ptspkt_pkg::ST_EMIT;
            end
            ptspkt_pkg::ST_EMIT:
            begin
                if (pkt_done)
                    state_next = ptspkt_pkg::ST_IDLE;
            end
            ptspkt_pkg::ST_SPLIT:
            begin
                if (pkt_done)
                    state_next = ptspkt_pkg::ST_EMIT;
            end
            default:
            begin
                state_next = ptspkt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: buffer writes and packet commands.
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ptspkt_pkg::ST_IDLE);
        unique case (state_reg)
            ptspkt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.wr_en    = byte_valid;
                    cmd.wr_addr  = fill0;
                    cmd.latch_ts = opening;
                    cmd.start    = full || split || close_pkt;
                    cmd.off      = 8'd0;
                    cmd.take     = split ? ptspkt_pkg::SPLIT_TAKE : fill1;
                    cmd.pusi     = first0;
                    cmd.pcr      = pcr0;
                    cmd.cc       = cc_reg;
                    cmd.unit_end = last_byte && !split;
                end
            end
            ptspkt_pkg::ST_SPLIT:
            begin
                // The one byte left over goes out in a second stuffed packet.
                cmd.start    = pkt_done;
                cmd.off      = ptspkt_pkg::SPLIT_TAKE;
                cmd.take     = 8'd1;
                cmd.pusi     = 1'b0;
                cmd.pcr      = 1'b0;
                cmd.cc       = cc_reg;
                cmd.unit_end = 1'b1;
            end
            ptspkt_pkg::ST_EMIT:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // State and unit bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptspkt_pkg::ST_IDLE;
            fill_reg  <= 8'd0;
            cc_reg    <= 4'd0;
            first_reg <= 1'b0;
            pcr_reg   <= 1'b0;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.start)
                cc_reg <= cc_reg + 4'd1;
            if (accept)
            begin
                open_reg  <= !last_byte;
                fill_reg  <= clear_unit ? 8'd0 : fill1;
                first_reg <= clear_unit ? 1'b0 : first0;
                pcr_reg   <= clear_unit ? 1'b0 : pcr0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/ptspkt_datapath.sv @@
// Datapath for the PES to transport stream packetizer.
// Holds the payload buffer; packet bytes go one per unstalled cycle, packed into words.
// Depends on ptspkt_pkg.
`default_nettype none

module ptspkt_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ptspkt_pkg::dp_cmd_t  cmd,
    output logic                      pkt_done,
    input  wire logic [7:0]           data_byte,
    input  wire logic [32:0]          pts,
    input  wire logic                 cfg_valid,
    input  wire logic [12:0]          cfg_data,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [63:0]               ts_word,
    output logic [3:0]                byte_count,
    output logic                      packet_end,
    output logic                      unit_end
);

    // Byte of the 14-byte PES header at a given index.
    function automatic logic [7:0] pes_hdr_byte(input logic [3:0] idx, input logic [32:0] t);
        logic [7:0] b;
        begin
            b = ptspkt_pkg::PES_START_ZERO;
            unique case (idx)
                4'd0:  b = ptspkt_pkg::PES_START_ZERO;
                4'd1:  b = ptspkt_pkg::PES_START_ZERO;
                4'd2:  b = ptspkt_pkg::PES_START_ONE;
                4'd3:  b = ptspkt_pkg::PES_STREAM_ID;
                4'd4:  b = ptspkt_pkg::PES_START_ZERO;
                4'd5:  b = ptspkt_pkg::PES_START_ZERO;
                4'd6:  b = ptspkt_pkg::PES_FLAGS;
                4'd7:  b = ptspkt_pkg::PES_FLAGS;
                4'd8:  b = ptspkt_pkg::PES_HDR_DLEN;
                4'd9:  b = {ptspkt_pkg::PES_PTS_PREFIX, t[32:30], 1'b1};
                4'd10: b = t[29:22];
                4'd11: b = {t[21:15], 1'b1};
                4'd12: b = t[14:7];
                4'd13: b = {t[6:0], 1'b1};
                default: b = ptspkt_pkg::PES_START_ZERO;
            endcase
            return b;
        end
    endfunction

    logic [12:0] pid_reg;
    logic [32:0] ts_reg;
    logic [7:0]  off_reg;
    logic [7:0]  take_reg;
    logic        pusi_reg;
    logic        pcr_reg;
    logic [3:0]  cc_reg;
    logic        ue_reg;
    logic        busy_reg;
    logic [7:0]  pos_reg;

    logic [7:0]  mem [ptspkt_pkg::BODY_LEN];
    logic [7:0]  rd_q_reg;

    logic        b_valid_reg;
    logic        b_mem_reg;
    logic [7:0]  b_gen_reg;
    logic        b_last_reg;
    logic        b_ue_reg;

    logic [63:0] acc_reg;
    logic [2:0]  acnt_reg;

    logic        out_valid_reg;
    logic [63:0] ts_word_reg;
    logic [3:0]  byte_count_reg;
    logic        packet_end_reg;
    logic        unit_end_reg;

    logic        en;
    logic [7:0]  pstart;
    logic        in_pay;
    logic [7:0]  rd_addr;
    logic        hdr_sel;
    logic        mem_sel;
    logic        adapt;
    logic [7:0]  hdr_byte;
    logic [7:0]  gen_byte;
    logic [7:0]  byte_in;
    logic [63:0] acc_new;
    logic        word_done;

    // The whole pipeline moves only when the output register can take a word.
    assign en       = !out_valid_reg || !out_stall;
    assign pkt_done = busy_reg && en && (pos_reg == ptspkt_pkg::PKT_LAST);

    // Byte generator: transport header, adaptation field, or payload position.
    always_comb
    begin
        pstart  = ptspkt_pkg::PKT_LEN - take_reg;
        in_pay  = (pos_reg >= pstart);
        rd_addr = off_reg + (pos_reg - pstart);
        hdr_sel = pusi_reg && (rd_addr < ptspkt_pkg::HDR_LEN);
        mem_sel = in_pay && !hdr_sel;
        adapt   = pcr_reg || (take_reg < ptspkt_pkg::BODY_LEN);

        priority if (pos_reg == 8'd0)
            hdr_byte = ptspkt_pkg::SYNC_BYTE;
        else if (pos_reg == 8'd1)
            hdr_byte = {1'b0, pusi_reg, 1'b0, pid_reg[12:8]};
        else if (pos_reg == 8'd2)
            hdr_byte = pid_reg[7:0];
        else if (pos_reg == 8'd3)
            hdr_byte = {adapt ? ptspkt_pkg::AFC_ADAPT_PAY : ptspkt_pkg::AFC_PAYLOAD, cc_reg};
        else if (pos_reg == 8'd4)
            hdr_byte = ptspkt_pkg::AF_LEN_BASE - take_reg;
        else if (pos_reg == 8'd5)
            hdr_byte = pcr_reg ? ptspkt_pkg::AF_FLAGS_PCR : ptspkt_pkg::AF_FLAGS_NONE;
        else if (pcr_reg && (pos_reg == 8'd6))
            hdr_byte = ts_reg[32:25];
        else if (pcr_reg && (pos_reg == 8'd7))
            hdr_byte = ts_reg[24:17];
        else if (pcr_reg && (pos_reg == 8'd8))
            hdr_byte = ts_reg[16:9];
        else if (pcr_reg && (pos_reg == 8'd9))
            hdr_byte = ts_reg[8:1];
        else if (pcr_reg && (pos_reg == 8'd10))
            hdr_byte = {ts_reg[0], ptspkt_pkg::PCR_EXT_MARK};
        else if (pcr_reg && (pos_reg == 8'd11))
            hdr_byte = ptspkt_pkg::PCR_EXT_LOW;
        else
            hdr_byte = ptspkt_pkg::STUFF_BYTE;

        gen_byte = in_pay ? pes_hdr_byte(rd_addr[3:0], ts_reg) : hdr_byte;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pid_reg <= ptspkt_pkg::PID_RESET;
        else if (cfg_valid)
            pid_reg <= cfg_data;
    end

    // Timestamp and packet parameters, loaded on command.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_ts)
            ts_reg <= pts;
        if (cmd.start)
        begin
            off_reg  <= cmd.off;
            take_reg <= cmd.take;
            pusi_reg <= cmd.pusi;
            pcr_reg  <= cmd.pcr;
            cc_reg   <= cmd.cc;
            ue_reg   <= cmd.unit_end;
        end
    end

    // Packet byte position counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 8'd0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= 8'd0;
        end
        else if (busy_reg && en)
        begin
            if (pos_reg == ptspkt_pkg::PKT_LAST)
                busy_reg <= 1'b0;
            else
                pos_reg <= pos_reg + 8'd1;
        end
    end

    // Payload buffer: one write port from the input, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= data_byte;
        if (busy_reg && en && mem_sel)
            rd_q_reg <= mem[rd_addr];
    end

    // Byte stage, aligned with the buffer read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= busy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_mem_reg  <= mem_sel;
            b_gen_reg  <= gen_byte;
            b_last_reg <= (pos_reg == ptspkt_pkg::PKT_LAST);
            b_ue_reg   <= ue_reg;
        end
    end

    // Word packing: eight bytes a word, four on the last word of a packet.
    always_comb
    begin
        byte_in   = b_mem_reg ? rd_q_reg : b_gen_reg;
        acc_new   = {acc_reg[55:0], byte_in};
        word_done = b_valid_reg && (b_last_reg || (acnt_reg == 3'd7));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acnt_reg <= 3'd0;
        else if (en && b_valid_reg)
            acnt_reg <= b_last_reg ? 3'd0 : acnt_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en && b_valid_reg)
            acc_reg <= acc_new;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= word_done;
    end

    always_ff @(posedge clk)
    begin
        if (en && word_done)
        begin
            ts_word_reg    <= b_last_reg ? {acc_new[31:0], 32'h0} : acc_new;
            byte_count_reg <= b_last_reg ? 4'd4 : 4'd8;
            packet_end_reg <= b_last_reg;
            unit_end_reg   <= b_last_reg && b_ue_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ts_word    = ts_word_reg;
    assign byte_count = byte_count_reg;
    assign packet_end = packet_end_reg;
    assign unit_end   = unit_end_reg;

endmodule

`default_nettype wire

@@ design/pes_to_transport_packetizer_core.sv @@
// An input beat that fills or closes a packet starts the byte generator, which builds the
// packet one byte per cycle while the output is not stalled, reading payload from the
// registered read port of the payload buffer; the packet leaves as 24 words.
// Input beats are taken one per cycle while bytes collect; input stalls while each packet is
// generated. Reset clears the controller state, the datapath counters and valid flags, and
// sets the PID to 256; buffer contents and the held packet parameters are not cleared.
`default_nettype none

module pes_to_transport_packetizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        last_byte,
    input  wire logic        key_frame,
    input  wire logic [32:0] pts,
    // Output channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      ts_word,
    output logic [3:0]       byte_count,
    output logic             packet_end,
    output logic             unit_end,
    // Configuration channel: video PID.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);

    ptspkt_pkg::dp_cmd_t cmd;
    logic                pkt_done;

    // The PID register takes a write on any cycle.
    assign cfg_ready = 1'b1;

    ptspkt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .key_frame  (key_frame),
        .pkt_done   (pkt_done),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    ptspkt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pkt_done   (pkt_done),
        .data_byte  (data_byte),
        .pts        (pts),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .ts_word    (ts_word),
        .byte_count (byte_count),
        .packet_end (packet_end),
        .unit_end   (unit_end)
    );

endmodule

`default_nettype wire

@@ design/ptspkt_checker.sv @@
// Port-level checks for the PES to transport stream packetizer.
// Bound to pes_to_transport_packetizer_core; uses its clock, reset and output channel ports only.
`default_nettype none

module ptspkt_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] ts_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        packet_end,
    input  wire logic        unit_end
);

    // Only the closing word of a packet is short, and it is always four bytes.
    a_word_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packet_end ? (byte_count == 4'd4) : (byte_count == 4'd8)))
        else $error("word size does not match packet position");

    // A unit always ends on a packet boundary.
    a_unit_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && unit_end) |-> packet_end)
        else $error("unit end marked inside a packet");

    // Unused low bytes of the short word are zero.
    a_short_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && packet_end) |-> (ts_word[31:0] == 32'h0))
        else $error("short word carries data in unused bytes");

    // A stalled beat stays on the port with its word and packet end unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ts_word) && $stable(packet_end)))
        else $error("output beat changed while stalled");

endmodule

bind pes_to_transport_packetizer_core ptspkt_checker u_ptspkt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ts_word    (ts_word),
    .byte_count (byte_count),
    .packet_end (packet_end),
    .unit_end   (unit_end)
);

`default_nettype wire

@@ sim/tb_pes_to_transport_packetizer_core.sv @@
// Self-checking testbench for the PES to transport stream packetizer core.
// A predictor builds the expected 64-bit stream words per input beat and checks them in order.
// Depends on ptspkt_pkg and pes_to_transport_packetizer_core.
`timescale 1ns / 100ps

module tb_pes_to_transport_packetizer_core;

    localparam int WORDS_PER_PKT = 24;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_BEATS   = 15;
    localparam logic [7:0] PES_LEN_OPEN = 8'h00;

    // One expected output beat.
    typedef struct {
        logic [63:0] tsw;
        logic [3:0]  nbytes;
        logic        pkt_end;
        logic        au_end;
    } ts_word_t;

    // Predicts the transport words of the stream and checks the observed ones.
    class ts_word_predictor;
        logic [7:0]  pay_buf [ptspkt_pkg::BODY_LEN];
        int unsigned fill;
        logic [3:0]  cc;
        bit          first_pend;
        bit          pcr_pend;
        bit          unit_open;
        logic [32:0] held_pts;
        logic [12:0] pid;
        logic [7:0]  pkt_q [$];
        ts_word_t    pending_ts_words [$];
        int          errors;

        function new();
            fill       = 0;
            cc         = '0;
            first_pend = 1'b0;
            pcr_pend   = 1'b0;
            unit_open  = 1'b0;
            held_pts   = '0;
            pid        = ptspkt_pkg::PID_RESET;
            errors     = 0;
        endfunction

        // Build one 188-byte packet from the held payload and queue its 24 words.
        function void emit_packet(int unsigned off, int unsigned take);
            int unsigned pcr_len;
            int unsigned maxp;
            int unsigned stuff;
            int unsigned nb;
            int          i;
            int          b;
            logic [7:0]  af_len;
            logic [63:0] w;
            ts_word_t    tw;
            pkt_q.delete();
            pkt_q.push_back(ptspkt_pkg::SYNC_BYTE);
            pkt_q.push_back({1'b0, first_pend, 1'b0, pid[12:8]});
            pkt_q.push_back(pid[7:0]);
            if (!pcr_pend && take >= ptspkt_pkg::BODY_LEN)
            begin
                pkt_q.push_back({ptspkt_pkg::AFC_PAYLOAD, cc});
                take = ptspkt_pkg::BODY_LEN;
            end
            else
            begin
                pcr_len = pcr_pend ? 6 : 0;
                maxp = ptspkt_pkg::BODY_LEN - 2 - pcr_len;
                if (take > maxp)
                    take = maxp;
                stuff = maxp - take;
                af_len = 8'(1 + pcr_len + stuff);
                pkt_q.push_back({ptspkt_pkg::AFC_ADAPT_PAY, cc});
                pkt_q.push_back(af_len);
                pkt_q.push_back(pcr_pend ? ptspkt_pkg::AF_FLAGS_PCR : ptspkt_pkg::AF_FLAGS_NONE);
                // The PCR base equals the held PTS; the extension is zero.
                if (pcr_pend)
                begin
                    pkt_q.push_back(held_pts[32:25]);
                    pkt_q.push_back(held_pts[24:17]);
                    pkt_q.push_back(held_pts[16:9]);
                    pkt_q.push_back(held_pts[8:1]);
                    pkt_q.push_back({held_pts[0], ptspkt_pkg::PCR_EXT_MARK});
                    pkt_q.push_back(ptspkt_pkg::PCR_EXT_LOW);
                end
                for (i = 0; i < stuff; i++)
                    pkt_q.push_back(ptspkt_pkg::STUFF_BYTE);
            end
            for (i = 0; i < take; i++)
                pkt_q.push_back(pay_buf[(off + i) % ptspkt_pkg::BODY_LEN]);

            cc = cc + 4'd1;
            first_pend = 1'b0;
            pcr_pend = 1'b0;

            // Pack bytes into words, first byte in the top lane.
            for (i = 0; i < WORDS_PER_PKT; i++)
            begin
                nb = (i < WORDS_PER_PKT - 1) ? 8 : 4;
                w = '0;
                for (b = 0; b < nb; b++)
                    w[63 - 8 * b -: 8] = pkt_q[i * 8 + b];
                tw.tsw = w;
                tw.nbytes = 4'(nb);
                tw.pkt_end = (i == WORDS_PER_PKT - 1);
                tw.au_end = 1'b0;
                pending_ts_words.push_back(tw);
            end
        endfunction

        // Account for one accepted input beat.
        function void note_pes_beat(logic [7:0] d, logic bv, logic lst, logic kf,
                                    logic [32:0] t);
            int n0;
            n0 = pending_ts_words.size();

            // The first beat of a unit latches the flags and lays down the PES header.
            if (!unit_open)
            begin
                held_pts = t;
                pcr_pend = kf;
                first_pend = 1'b1;
                unit_open = 1'b1;
                pay_buf[0] = ptspkt_pkg::PES_START_ZERO;
                pay_buf[1] = ptspkt_pkg::PES_START_ZERO;
                pay_buf[2] = ptspkt_pkg::PES_START_ONE;
                pay_buf[3] = ptspkt_pkg::PES_STREAM_ID;
                pay_buf[4] = PES_LEN_OPEN;
                pay_buf[5] = PES_LEN_OPEN;
                pay_buf[6] = ptspkt_pkg::PES_FLAGS;
                pay_buf[7] = ptspkt_pkg::PES_FLAGS;
                pay_buf[8] = ptspkt_pkg::PES_HDR_DLEN;
                pay_buf[9] = {ptspkt_pkg::PES_PTS_PREFIX, t[32:30], 1'b1};
                pay_buf[10] = t[29:22];
                pay_buf[11] = {t[21:15], 1'b1};
                pay_buf[12] = t[14:7];
                pay_buf[13] = {t[6:0], 1'b1};
                fill = ptspkt_pkg::HDR_LEN;
            end

            if (bv && fill < ptspkt_pkg::BODY_LEN)
            begin
                pay_buf[fill] = d;
                fill++;
            end

            if (fill >= (pcr_pend ? ptspkt_pkg::PCR_BODY : ptspkt_pkg::BODY_LEN))
            begin
                emit_packet(0, fill);
                fill = 0;
            end

            // Closing the unit flushes what is held; 183 bytes need two packets.
            if (lst)
            begin
                if (fill == ptspkt_pkg::BODY_LAST && !pcr_pend)
                begin
                    emit_packet(0, ptspkt_pkg::SPLIT_TAKE);
                    emit_packet(ptspkt_pkg::SPLIT_TAKE, 1);
                end
                else if (fill > 0)
                    emit_packet(0, fill);
                fill = 0;
                unit_open = 1'b0;
                first_pend = 1'b0;
                pcr_pend = 1'b0;
                if (pending_ts_words.size() > n0)
                    pending_ts_words[pending_ts_words.size() - 1].au_end = 1'b1;
            end
        endfunction

        // Compare an accepted output beat with the oldest expected word.
        function void check_ts_word(logic [63:0] w, logic [3:0] nb, logic pe, logic ue);
            ts_word_t want;
            if (pending_ts_words.size() == 0)
            begin
                $display("%0t: output word %h arrived with none expected", $time, w);
                errors++;
                return;
            end
            want = pending_ts_words.pop_front();
            if (w !== want.tsw)
            begin
                $display("%0t: ts_word expected %h, got %h", $time, want.tsw, w);
                errors++;
            end
            if (nb !== want.nbytes)
            begin
                $display("%0t: byte_count expected %0d, got %0d", $time, want.nbytes, nb);
                errors++;
            end
            if (pe !== want.pkt_end)
            begin
                $display("%0t: packet_end expected %b, got %b", $time, want.pkt_end, pe);
                errors++;
            end
            if (ue !== want.au_end)
            begin
                $display("%0t: unit_end expected %b, got %b", $time, want.au_end, ue);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_valid = 1'b0;
    logic        last_byte = 1'b0;
    logic        key_frame = 1'b0;
    logic [32:0] pts = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] ts_word;
    logic [3:0]  byte_count;
    logic        packet_end;
    logic        unit_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;

    ts_word_predictor predictor;
    int send_idle_pct = 7;
    int recv_stall_pct = 64;
    int beats_accepted = 0;
    int cycle_count = 0;

    pes_to_transport_packetizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .key_frame  (key_frame),
        .pts        (pts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ts_word    (ts_word),
        .byte_count (byte_count),
        .packet_end (packet_end),
        .unit_end   (unit_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check every accepted output beat.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            predictor.check_ts_word(ts_word, byte_count, packet_end, unit_end);
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [32:0] rand_pts();
        logic [32:0] v;
        v[31:0] = $urandom();
        v[32] = 1'($urandom_range(1));
        return v;
    endfunction

    // Drive one input beat from a falling edge and hold it until it is taken.
    task automatic send_beat(input logic [7:0] d, input logic bv, input logic lst,
                             input logic kf, input logic [32:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        byte_valid <= bv;
        last_byte <= lst;
        key_frame <= kf;
        pts <= t;
        do
            @(posedge clk);
        while (in_stall);
        predictor.note_pes_beat(d, bv, lst, kf, t);
        beats_accepted++;
        @(negedge clk);
    endtask

    // Send one access unit of nbytes data bytes with random content and a few empty beats.
    // Key and timestamp only matter on the first beat; later beats carry random values.
    task automatic send_unit(input int nbytes, input bit kf, input logic [32:0] t,
                             input bit sep_close);
        bit first;
        bit closes;
        int k;
        first = 1'b1;
        for (k = 0; k < nbytes; k++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_beat(8'($urandom_range(255)), 1'b0, 1'b0,
                          first ? kf : 1'($urandom_range(1)), first ? t : rand_pts());
                first = 1'b0;
            end
            closes = (k == nbytes - 1) && !sep_close;
            send_beat(8'($urandom_range(255)), 1'b1, closes,
                      first ? kf : 1'($urandom_range(1)), first ? t : rand_pts());
            first = 1'b0;
        end
        if (nbytes == 0 || sep_close)
            send_beat(8'($urandom_range(255)), 1'b0, 1'b1,
                      first ? kf : 1'($urandom_range(1)), first ? t : rand_pts());
    endtask

    // Drop valid, wait for every expected word, then let the packet generator go quiet.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (predictor.pending_ts_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_pid(input logic [12:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        predictor.pid = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int target;
        int nb;
        predictor = new();

        // Hold reset, then release it on a falling edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty units give header-only packets, with and without a PCR.
        send_beat(8'h00, 1'b0, 1'b1, 1'b0, 33'h0_0000_0000);
        send_beat(8'hFF, 1'b0, 1'b1, 1'b1, 33'h1_FFFF_FFFF);
        // One-byte units at the data extremes.
        send_beat(8'h00, 1'b1, 1'b1, 1'b0, 33'h1_0000_0000);
        send_beat(8'hFF, 1'b1, 1'b1, 1'b1, 33'h0_AAAA_5555);
        // Empty beats inside a unit, and an empty beat that closes it.
        send_beat(8'hA5, 1'b1, 1'b0, 1'b0, 33'h0_5555_AAAA);
        send_beat(8'h3C, 1'b0, 1'b0, 1'b1, 33'h1_FFFF_FFFF);
        send_beat(8'h5A, 1'b1, 1'b0, 1'b1, 33'h0_0000_0000);
        send_beat(8'hC3, 1'b0, 1'b1, 1'b0, 33'h1_2345_6789);
        // Key-frame unit with alternating timestamp bits.
        send_beat(8'h80, 1'b1, 1'b0, 1'b1, 33'h1_5555_AAAA);
        send_beat(8'h7F, 1'b1, 1'b1, 1'b0, 33'h0_AAAA_5555);

        // Three random phases, each under its own PID and idling mix.
        for (ph = 0; ph < 3; ph++)
        begin
            drain_and_settle();
            case (ph)
                0: write_pid(13'h0000);
                1: write_pid(13'h1FFF);
                default: write_pid(13'($urandom_range(13'h1FFF)));
            endcase
            send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 64 : 0;
            recv_stall_pct = (ph == 0) ? 64 : (ph == 1) ? 7 : 0;
            target = beats_accepted + PHASE_BEATS;

            // 169 data bytes leave 183 held at the close: split into 182 and 1.
            if (ph == 0)
                send_unit(169, 1'b0, rand_pts(), 1'b0);

            // Mostly short units with random content.
            while (beats_accepted < target)
            begin
                nb = ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(13, 60);
                send_unit(nb, ($urandom_range(99) < 30), rand_pts(), ($urandom_range(99) < 10));
            end
        end

        drain_and_settle();
        if (predictor.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
